/* hdl/lcst_pkg.sv */
// Shared types and constants for the leg contact state tracker.
// Used by the lane, merge and top-level modules; depends on nothing else.
`default_nettype none

package lcst_pkg;

  // Number of legs handled side by side
  localparam int unsigned NUM_LEGS = 4;

  // Default field widths
  localparam int unsigned PHASE_BITS_DEF = 16;
  localparam int unsigned SPEED_BITS_DEF = 16;
  localparam int unsigned RUN_BITS_DEF   = 8;

  // Configuration register widths
  localparam int unsigned TPS_W = 16;
  localparam int unsigned DEB_W = 8;
  localparam int unsigned THR_W = 15;

  // Configuration bus
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Configuration register reset values
  localparam logic [TPS_W-1:0] TPS_RESET = 16'd32768;
  localparam logic [DEB_W-1:0] DEB_RESET = 8'd1;
  localparam logic [THR_W-1:0] THR_RESET = 15'd77;

  // Register indexes (word address bits)
  typedef enum logic [1:0] {
    REG_TPS = 2'd0,
    REG_DEB = 2'd1,
    REG_THR = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_e;

  // Leg mode encoding
  typedef enum logic [1:0] {
    MODE_STANCE = 2'd0,
    MODE_SWING  = 2'd1,
    MODE_EARLY  = 2'd2,
    MODE_LATE   = 2'd3
  } leg_mode_e;

  // Configuration seen by every lane
  typedef struct packed {
    logic [TPS_W-1:0] touchdown_phase_start;
    logic [DEB_W-1:0] debounce_length;
    logic [THR_W-1:0] speed_threshold;
  } cfg_t;

  // Handshake control from the merge stage to the lanes
  typedef struct packed {
    logic accept;
  } lane_ctl_t;

endpackage

`default_nettype wire

/* hdl/lcst_lane.sv */
// One leg lane: contact confirmation, saturating run counter and mode machine.
// Depends on lcst_pkg for the configuration struct and mode encoding.
`default_nettype none

module lcst_lane #(
  parameter int unsigned PHASE_BITS = lcst_pkg::PHASE_BITS_DEF,
  parameter int unsigned SPEED_BITS = lcst_pkg::SPEED_BITS_DEF,
  parameter int unsigned RUN_BITS   = lcst_pkg::RUN_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  lcst_pkg::lane_ctl_t         ctl_i,
  input  lcst_pkg::cfg_t              cfg_i,
  input  wire                         flag_i,
  input  wire                         stance_i,
  input  wire        [PHASE_BITS-1:0] phase_i,
  input  wire signed [SPEED_BITS-1:0] speed_i,
  output lcst_pkg::leg_mode_e         mode_o
);

  localparam int unsigned PW = (PHASE_BITS > lcst_pkg::TPS_W) ? PHASE_BITS : lcst_pkg::TPS_W;
  localparam int unsigned SW = (SPEED_BITS > lcst_pkg::THR_W) ? SPEED_BITS : lcst_pkg::THR_W;
  localparam int unsigned CW = (RUN_BITS > lcst_pkg::DEB_W) ? RUN_BITS : lcst_pkg::DEB_W;

  lcst_pkg::leg_mode_e mode_q, mode_d;
  logic [RUN_BITS-1:0] run_q, run_d;

  logic [SPEED_BITS-1:0] spd_u;
  logic [SPEED_BITS-1:0] mag;
  logic                  confirmed;
  logic [CW-1:0]         deb_ext;
  logic [CW-1:0]         run_max_ext;
  logic [RUN_BITS-1:0]   cap;
  logic [RUN_BITS:0]     run_inc;
  logic                  debounced;
  logic                  phase_late;

  // Confirm contact: flag set and |speed| below threshold
  assign spd_u     = speed_i;
  assign mag       = spd_u[SPEED_BITS-1] ? (~spd_u + 1'b1) : spd_u;
  assign confirmed = flag_i && (SW'(mag) < SW'(cfg_i.speed_threshold));

  // Cap the run at the debounce length, clipped to the counter range
  assign deb_ext     = CW'(cfg_i.debounce_length);
  assign run_max_ext = CW'({RUN_BITS{1'b1}});
  assign cap         = (deb_ext > run_max_ext) ? {RUN_BITS{1'b1}} : RUN_BITS'(deb_ext);
  assign run_inc     = {1'b0, run_q} + 1'b1;

  // Advance or drop the run counter
  always_comb begin
    if (!confirmed) begin
      run_d = '0;
    end else if (run_inc > {1'b0, cap}) begin
      run_d = cap;
    end else begin
      run_d = run_inc[RUN_BITS-1:0];
    end
  end

  assign debounced  = confirmed && (CW'(run_d) >= deb_ext);
  assign phase_late = PW'(phase_i) > PW'(cfg_i.touchdown_phase_start);

  // Step the leg mode machine
  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      lcst_pkg::MODE_SWING: begin
        if (stance_i) begin
          mode_d = debounced ? lcst_pkg::MODE_STANCE : lcst_pkg::MODE_LATE;
        end else if (debounced && phase_late) begin
          mode_d = lcst_pkg::MODE_EARLY;
        end
      end
      lcst_pkg::MODE_STANCE: begin
        if (!stance_i) begin
          mode_d = lcst_pkg::MODE_SWING;
        end
      end
      lcst_pkg::MODE_LATE: begin
        if (debounced) begin
          mode_d = lcst_pkg::MODE_STANCE;
        end
      end
      lcst_pkg::MODE_EARLY: begin
        if (stance_i) begin
          mode_d = lcst_pkg::MODE_STANCE;
        end
      end
      default: mode_d = lcst_pkg::MODE_STANCE;
    endcase
  end

  // Hold lane state between accepted items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lcst_pkg::MODE_STANCE;
      run_q  <= '0;
    end else if (ctl_i.accept) begin
      mode_q <= mode_d;
      run_q  <= run_d;
    end
  end

  assign mode_o = mode_d;

endmodule

`default_nettype wire

/* hdl/lcst_merge.sv */
// Merge stage: collects the four lane modes into one output register.
// Owns the item handshake on both channels; depends on lcst_pkg.
`default_nettype none

module lcst_merge (
  input  wire                                             clk_i,
  input  wire                                             rst_ni,
  input  wire                                             in_valid_i,
  output logic                                            in_stall_o,
  input  wire                                             out_stall_i,
  output logic                                            out_valid_o,
  input  lcst_pkg::leg_mode_e [lcst_pkg::NUM_LEGS-1:0]    mode_i,
  output lcst_pkg::lane_ctl_t                             ctl_o,
  output logic [lcst_pkg::NUM_LEGS-1:0][1:0]              state_o
);

  logic                                      valid_q, valid_d;
  logic [lcst_pkg::NUM_LEGS-1:0][1:0]        state_q;
  logic                                      accept;

  // Take a new item whenever the output register is free or drains this cycle
  assign in_stall_o   = valid_q && out_stall_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign ctl_o.accept = accept;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load the merged result on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < lcst_pkg::NUM_LEGS; i++) begin
        state_q[i] <= mode_i[i];
      end
    end
  end

  assign out_valid_o = valid_q;
  assign state_o     = state_q;

endmodule

`default_nettype wire

/* hdl/leg_contact_state_tracker.sv */
// Leg contact state tracker: four parallel leg lanes, a merge stage and the
// configuration registers. Depends on lcst_pkg, lcst_lane and lcst_merge.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one control tick: contact
//   flags, desired stance bits, and a phase and vertical speed per leg.
//   Output channel (out_valid_o / out_stall_i) returns the four leg states
//   after that tick's update, one result item per input item.
//   An accepted item shows its result in the next cycle. Throughput is one item
//   per cycle while the receiver does not stall; all four lanes update in the
//   same cycle and the output register holds the merged result.
//   While the receiver stalls with a result pending, in_stall_o is high and
//   no new item is taken; lane state does not move, so no item is lost.
//   Reset puts every leg in stance, clears the run counters and loads the
//   register reset values (touchdown phase 32768, debounce 1, threshold 77).
//   Registers sit at byte addresses 0, 4 and 8 on the APB port; write them
//   only while the block is idle.
`default_nettype none

module leg_contact_state_tracker #(
  parameter int unsigned PHASE_BITS = lcst_pkg::PHASE_BITS_DEF,
  parameter int unsigned SPEED_BITS = lcst_pkg::SPEED_BITS_DEF,
  parameter int unsigned RUN_BITS   = lcst_pkg::RUN_BITS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration port
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [lcst_pkg::PADDR_W-1:0]        paddr,
  input  wire  [lcst_pkg::PDATA_W-1:0]        pwdata,
  output logic [lcst_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // input channel
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [3:0]                          contact_flags_i,
  input  wire  [3:0]                          desired_stance_i,
  input  wire  [PHASE_BITS-1:0]               leg0_phase_i,
  input  wire  [PHASE_BITS-1:0]               leg1_phase_i,
  input  wire  [PHASE_BITS-1:0]               leg2_phase_i,
  input  wire  [PHASE_BITS-1:0]               leg3_phase_i,
  input  wire signed [SPEED_BITS-1:0]         leg0_vertical_speed_i,
  input  wire signed [SPEED_BITS-1:0]         leg1_vertical_speed_i,
  input  wire signed [SPEED_BITS-1:0]         leg2_vertical_speed_i,
  input  wire signed [SPEED_BITS-1:0]         leg3_vertical_speed_i,
  // output channel
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [1:0]                          leg0_contact_state_o,
  output logic [1:0]                          leg1_contact_state_o,
  output logic [1:0]                          leg2_contact_state_o,
  output logic [1:0]                          leg3_contact_state_o
);

  lcst_pkg::cfg_t    cfg_q, cfg_d;
  lcst_pkg::reg_idx_e reg_idx;
  logic              cfg_wr;

  logic [lcst_pkg::NUM_LEGS-1:0][PHASE_BITS-1:0]        phase;
  logic signed [SPEED_BITS-1:0]                         speed [lcst_pkg::NUM_LEGS];
  lcst_pkg::leg_mode_e [lcst_pkg::NUM_LEGS-1:0]         mode;
  logic [lcst_pkg::NUM_LEGS-1:0][1:0]                   state;
  lcst_pkg::lane_ctl_t                                  ctl;

  // Decode register writes
  assign pready  = 1'b1;
  assign reg_idx = lcst_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        lcst_pkg::REG_TPS: cfg_d.touchdown_phase_start = pwdata[lcst_pkg::TPS_W-1:0];
        lcst_pkg::REG_DEB: cfg_d.debounce_length       = pwdata[lcst_pkg::DEB_W-1:0];
        lcst_pkg::REG_THR: cfg_d.speed_threshold       = pwdata[lcst_pkg::THR_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.touchdown_phase_start <= lcst_pkg::TPS_RESET;
      cfg_q.debounce_length       <= lcst_pkg::DEB_RESET;
      cfg_q.speed_threshold       <= lcst_pkg::THR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back registers
  always_comb begin
    case (reg_idx)
      lcst_pkg::REG_TPS: prdata = lcst_pkg::PDATA_W'(cfg_q.touchdown_phase_start);
      lcst_pkg::REG_DEB: prdata = lcst_pkg::PDATA_W'(cfg_q.debounce_length);
      lcst_pkg::REG_THR: prdata = lcst_pkg::PDATA_W'(cfg_q.speed_threshold);
      default:           prdata = '0;
    endcase
  end

  // Spread the item fields over the lanes
  assign phase[0] = leg0_phase_i;
  assign phase[1] = leg1_phase_i;
  assign phase[2] = leg2_phase_i;
  assign phase[3] = leg3_phase_i;
  assign speed[0] = leg0_vertical_speed_i;
  assign speed[1] = leg1_vertical_speed_i;
  assign speed[2] = leg2_vertical_speed_i;
  assign speed[3] = leg3_vertical_speed_i;

  for (genvar g = 0; g < lcst_pkg::NUM_LEGS; g++) begin : g_lane
    lcst_lane #(
      .PHASE_BITS(PHASE_BITS),
      .SPEED_BITS(SPEED_BITS),
      .RUN_BITS  (RUN_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .cfg_i   (cfg_q),
      .flag_i  (contact_flags_i[g]),
      .stance_i(desired_stance_i[g]),
      .phase_i (phase[g]),
      .speed_i (speed[g]),
      .mode_o  (mode[g])
    );
  end

  lcst_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .mode_i     (mode),
    .ctl_o      (ctl),
    .state_o    (state)
  );

  assign leg0_contact_state_o = state[0];
  assign leg1_contact_state_o = state[1];
  assign leg2_contact_state_o = state[2];
  assign leg3_contact_state_o = state[3];

  // An accepted item always yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.accept |=> out_valid_o)
    else $error("accepted item produced no result");

  // Stall toward the sender only while a result waits on a stalled receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a pending stalled result");

  // A debounce register write lands in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (reg_idx == lcst_pkg::REG_DEB))
      |=> (cfg_q.debounce_length == $past(pwdata[lcst_pkg::DEB_W-1:0])))
    else $error("debounce length write lost");

endmodule

`default_nettype wire

/* bench/lcst_checker.sv */
// Checker for the leg contact state tracker: follows the APB register writes,
// checks register reads, predicts the four leg states for every accepted tick
// and compares results. Depends on lcst_pkg.
module lcst_checker
  import lcst_pkg::*;
(
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  // configuration port, observed
  input  wire                                      psel_i,
  input  wire                                      penable_i,
  input  wire                                      pwrite_i,
  input  wire                                      pready_i,
  input  wire  [PADDR_W-1:0]                       paddr_i,
  input  wire  [PDATA_W-1:0]                       pwdata_i,
  input  wire  [PDATA_W-1:0]                       prdata_i,
  // input channel, observed
  input  wire                                      in_valid_i,
  input  wire                                      in_stall_i,
  input  wire  [NUM_LEGS-1:0]                      contact_flags_i,
  input  wire  [NUM_LEGS-1:0]                      desired_stance_i,
  input  wire  [NUM_LEGS-1:0][PHASE_BITS_DEF-1:0]  leg_phase_i,
  input  wire  [NUM_LEGS-1:0][SPEED_BITS_DEF-1:0]  leg_speed_i,
  // output channel, observed
  input  wire                                      out_valid_i,
  input  wire                                      out_stall_i,
  input  wire  [NUM_LEGS-1:0][1:0]                 leg_state_i,
  // status to the bench top
  output int unsigned                              fail_count_o,
  output int unsigned                              pending_o
);

  localparam int unsigned SP_W       = SPEED_BITS_DEF;
  localparam int unsigned RUN_W      = RUN_BITS_DEF;
  localparam int unsigned REPORT_MAX = 10;

  cfg_t                     cfg_q;
  leg_mode_e                mode_q [NUM_LEGS];
  logic [RUN_W-1:0]         run_q  [NUM_LEGS];
  logic [NUM_LEGS-1:0][1:0] expected_states [$];
  int unsigned              mismatches;

  // Absolute value of a two's complement speed, one bit wider
  function automatic logic [SP_W:0] speed_mag(input logic [SP_W-1:0] raw);
    logic [SP_W:0] full;
    full = '0;
    full[SP_W] = 1'b1;
    if (raw[SP_W-1]) return full - {1'b0, raw};
    return {1'b0, raw};
  endfunction

  // Step every leg on the item now on the input ports
  task automatic predict_tick(output logic [NUM_LEGS-1:0][1:0] states);
    logic           confirmed;
    logic           debounced;
    logic           to_stance;
    logic [RUN_W:0] run_next;
    for (int i = 0; i < NUM_LEGS; i++) begin
      to_stance = desired_stance_i[i];
      confirmed = contact_flags_i[i] &&
                  (speed_mag(leg_speed_i[i]) < cfg_q.speed_threshold);
      // saturate the run at the debounce length, clear it on a miss
      if (confirmed) begin
        run_next = {1'b0, run_q[i]} + 1'b1;
        if (run_next > {1'b0, cfg_q.debounce_length})
          run_next = {1'b0, cfg_q.debounce_length};
        run_q[i] = run_next[RUN_W-1:0];
      end else begin
        run_q[i] = '0;
      end
      debounced = confirmed && (run_q[i] >= cfg_q.debounce_length);
      case (mode_q[i])
        MODE_SWING: begin
          if (!to_stance) begin
            if (debounced && (leg_phase_i[i] > cfg_q.touchdown_phase_start))
              mode_q[i] = MODE_EARLY;
          end else if (debounced) begin
            mode_q[i] = MODE_STANCE;
          end else begin
            mode_q[i] = MODE_LATE;
          end
        end
        MODE_STANCE: begin
          if (!to_stance) mode_q[i] = MODE_SWING;
        end
        MODE_LATE: begin
          if (debounced) mode_q[i] = MODE_STANCE;
        end
        default: begin
          if (to_stance) mode_q[i] = MODE_STANCE;
        end
      endcase
      states[i] = mode_q[i];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [NUM_LEGS-1:0][1:0] oldest;
    logic [NUM_LEGS-1:0][1:0] predicted;
    logic [PDATA_W-1:0]       reg_val;
    logic                     reg_known;
    if (!rst_ni) begin
      cfg_q.touchdown_phase_start = TPS_RESET;
      cfg_q.debounce_length       = DEB_RESET;
      cfg_q.speed_threshold       = THR_RESET;
      for (int i = 0; i < NUM_LEGS; i++) begin
        mode_q[i] = MODE_STANCE;
        run_q[i]  = '0;
      end
      expected_states.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // compare the result item leaving the block with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_states.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result item with nothing expected: states %h", leg_state_i);
        end else begin
          oldest = expected_states.pop_front();
          for (int i = 0; i < NUM_LEGS; i++) begin
            if (leg_state_i[i] !== oldest[i]) begin
              mismatches++;
              if (mismatches <= REPORT_MAX)
                $display("leg %0d state mismatch: expected %0d, got %0d",
                         i, oldest[i], leg_state_i[i]);
            end
          end
        end
      end

      // follow register writes, check register reads
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (reg_idx_e'(paddr_i[3:2]))
            REG_TPS: cfg_q.touchdown_phase_start = pwdata_i[TPS_W-1:0];
            REG_DEB: cfg_q.debounce_length       = pwdata_i[DEB_W-1:0];
            REG_THR: cfg_q.speed_threshold       = pwdata_i[THR_W-1:0];
            default: ;
          endcase
        end else begin
          reg_val   = '0;
          reg_known = 1'b1;
          case (reg_idx_e'(paddr_i[3:2]))
            REG_TPS: reg_val[TPS_W-1:0] = cfg_q.touchdown_phase_start;
            REG_DEB: reg_val[DEB_W-1:0] = cfg_q.debounce_length;
            REG_THR: reg_val[THR_W-1:0] = cfg_q.speed_threshold;
            default: reg_known = 1'b0;
          endcase
          if (reg_known && (prdata_i !== reg_val)) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("register read at %h: expected %h, got %h",
                       paddr_i, reg_val, prdata_i);
          end
        end
      end

      // predict the accepted item
      if (in_valid_i && !in_stall_i) begin
        predict_tick(predicted);
        expected_states.push_back(predicted);
      end

      pending_o    <= expected_states.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

/* bench/leg_contact_state_tracker_tb.sv */
// Bench top for the leg contact state tracker: clock, reset, APB programming,
// tick stimulus and receiver stalls. Depends on lcst_pkg, lcst_checker and the block.
module leg_contact_state_tracker_tb;
  import lcst_pkg::*;

  localparam int unsigned PH_W        = PHASE_BITS_DEF;
  localparam int unsigned SP_W        = SPEED_BITS_DEF;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned LONG_HOLD   = 60;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [PADDR_W-1:0]            paddr;
  logic [PDATA_W-1:0]            pwdata;
  wire  [PDATA_W-1:0]            prdata;
  wire                           pready;
  logic                          in_valid;
  wire                           in_stall;
  logic [NUM_LEGS-1:0]           flags_q;
  logic [NUM_LEGS-1:0]           stance_q;
  logic [NUM_LEGS-1:0][PH_W-1:0] phase_q;
  logic [NUM_LEGS-1:0][SP_W-1:0] speed_q;
  wire                           out_valid;
  logic                          out_stall;
  wire  [NUM_LEGS-1:0][1:0]      leg_state;
  int unsigned                   fail_count;
  int unsigned                   pending;

  // stimulus shaping state
  logic                          calm;
  logic                          rx_hold_req;
  logic [THR_W-1:0]              cur_thr;
  logic [NUM_LEGS-1:0][PH_W-1:0] gait_q;

  leg_contact_state_tracker u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .contact_flags_i       (flags_q),
    .desired_stance_i      (stance_q),
    .leg0_phase_i          (phase_q[0]),
    .leg1_phase_i          (phase_q[1]),
    .leg2_phase_i          (phase_q[2]),
    .leg3_phase_i          (phase_q[3]),
    .leg0_vertical_speed_i (speed_q[0]),
    .leg1_vertical_speed_i (speed_q[1]),
    .leg2_vertical_speed_i (speed_q[2]),
    .leg3_vertical_speed_i (speed_q[3]),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .leg0_contact_state_o  (leg_state[0]),
    .leg1_contact_state_o  (leg_state[1]),
    .leg2_contact_state_o  (leg_state[2]),
    .leg3_contact_state_o  (leg_state[3])
  );

  lcst_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .contact_flags_i  (flags_q),
    .desired_stance_i (stance_q),
    .leg_phase_i      (phase_q),
    .leg_speed_i      (speed_q),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .leg_state_i      (leg_state),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // One APB transfer: setup phase, access phase, then idle
  task automatic apb_access(input reg_idx_e idx, input logic write,
                            input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_all_regs();
    apb_access(REG_TPS, 1'b0, '0);
    apb_access(REG_DEB, 1'b0, '0);
    apb_access(REG_THR, 1'b0, '0);
  endtask

  // Drop valid and hold until every predicted item has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Program all registers while idle; junk in the upper bits must be dropped
  task automatic program_cfg(input logic [TPS_W-1:0] tps, input logic [DEB_W-1:0] deb,
                             input logic [THR_W-1:0] thr);
    logic [31:0] junk;
    settle();
    junk = $urandom;
    apb_access(REG_TPS, 1'b1, {junk[31:TPS_W], tps});
    apb_access(REG_DEB, 1'b1, {junk[31:DEB_W], deb});
    apb_access(REG_THR, 1'b1, {junk[31:THR_W], thr});
    apb_access(REG_NONE, 1'b1, $urandom);
    read_all_regs();
    cur_thr = thr;
  endtask

  // Offer one item and hold it until accepted
  task automatic send_tick(input logic [NUM_LEGS-1:0] flags,
                           input logic [NUM_LEGS-1:0] stance,
                           input logic [NUM_LEGS-1:0][PH_W-1:0] phase,
                           input logic [NUM_LEGS-1:0][SP_W-1:0] speed);
    in_valid <= 1'b1;
    flags_q  <= flags;
    stance_q <= stance;
    phase_q  <= phase;
    speed_q  <= speed;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Idle the sender for a short burst now and then
  task automatic maybe_gap();
    if (!calm && ($urandom_range(0, 3) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Mostly a walking gait with random content, the rest pure noise
  task automatic random_tick(input int unsigned noise_pct);
    logic [NUM_LEGS-1:0]           flags;
    logic [NUM_LEGS-1:0]           stance;
    logic [NUM_LEGS-1:0][PH_W-1:0] phase;
    logic [NUM_LEGS-1:0][SP_W-1:0] speed;
    logic [31:0]                   rnd;
    logic [31:0]                   mag;
    int unsigned                   roll;
    for (int i = 0; i < NUM_LEGS; i++) begin
      rnd = $urandom;
      if ($urandom_range(0, 99) < noise_pct) begin
        flags[i]  = rnd[0];
        stance[i] = rnd[1];
        phase[i]  = rnd[31:16];
        rnd       = $urandom;
        speed[i]  = rnd[15:0];
      end else begin
        // advance the leg through its cycle: stance in the lower half
        mag       = $urandom_range(300, 6000);
        gait_q[i] = gait_q[i] + mag[PH_W-1:0];
        phase[i]  = gait_q[i];
        stance[i] = (gait_q[i] < 16'h8000);
        if ($urandom_range(0, 9) == 0) stance[i] = ~stance[i];
        roll = $urandom_range(0, 99);
        if (stance[i])               flags[i] = (roll < 90);
        else if (gait_q[i] > 16'hC000) flags[i] = (roll < 45);
        else                         flags[i] = (roll < 5);
        // speed mostly inside the threshold, sometimes the most negative value
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          speed[i] = 16'h8000;
        end else if ((roll < 80) && (cur_thr != 0)) begin
          mag      = $urandom_range(0, cur_thr - 1);
          speed[i] = ($urandom_range(0, 1) == 1) ? (16'h0000 - mag[15:0]) : mag[15:0];
        end else begin
          speed[i] = rnd[15:0];
        end
      end
    end
    send_tick(flags, stance, phase, speed);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned noise_pct);
    repeat (count) begin
      maybe_gap();
      random_tick(noise_pct);
    end
  endtask

  // Receiver: random stall bursts, one long hold on request, none when calm
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (!calm && ($urandom_range(0, 3) == 0)) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Main stimulus
  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    flags_q     <= '0;
    stance_q    <= '0;
    phase_q     <= '0;
    speed_q     <= '0;
    calm        = 1'b0;
    rx_hold_req = 1'b0;
    cur_thr     = THR_RESET;
    for (int i = 0; i < NUM_LEGS; i++) gait_q[i] = PH_W'($urandom_range(0, 65535));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the registers
    read_all_regs();

    // directed ticks under reset settings
    send_tick(4'h0, 4'hF, '0, '0);
    send_tick(4'hF, 4'hF, {4{16'hFFFF}}, {4{16'h7FFF}});
    send_tick(4'h0, 4'h0, '0, '0);
    // contact exactly at the touchdown phase is not early
    send_tick(4'hF, 4'h0, {4{16'h8000}}, '0);
    // most negative speed never confirms contact
    maybe_gap();
    send_tick(4'hF, 4'h0, {4{16'h8001}}, {4{16'h8000}});
    // speed just inside and just at the threshold, both signs
    send_tick(4'hF, 4'h0, {4{16'hFFFF}}, {16'hFFB3, 16'h004D, 16'hFFB4, 16'h004C});
    send_tick(4'h0, 4'hF, '0, '0);
    send_tick(4'hF, 4'hF, '0, '0);
    maybe_gap();
    send_tick(4'h0, 4'h0, '0, '0);
    send_tick(4'hF, 4'hF, '0, '0);
    send_tick(4'h0, 4'h0, '0, '0);
    send_tick(4'hF, 4'hF, '0, {4{16'h7FFF}});
    send_tick(4'h5, 4'hF, '0, '0);
    maybe_gap();
    send_tick(4'hF, 4'hA, {4{16'hC000}}, '0);
    send_tick(4'hF, 4'h0, {4{16'hC000}}, {4{16'h00FF}});
    send_tick(4'h3, 4'h6, {16'h1234, 16'hFEDC, 16'h8000, 16'h7FFF},
              {16'h8001, 16'h0001, 16'hFFFF, 16'h0000});
    run_random(220, 20);

    // extremes: early at any nonzero phase, debounce off, widest threshold
    program_cfg(16'h0000, 8'd0, 15'h7FFF);
    run_random(120, 20);

    // opposite extremes: never early, longest debounce, nothing confirmed
    program_cfg(16'hFFFF, 8'd255, 15'h0000);
    run_random(100, 20);

    // receiver holds off while the sender keeps offering items
    program_cfg(16'($urandom_range(0, 65535)), 8'd3, 15'd500);
    rx_hold_req = 1'b1;
    run_random(200, 15);

    // long debounce, then build up runs before lowering it
    program_cfg(16'd16384, 8'd6, 15'd200);
    run_random(170, 10);
    repeat (8) begin
      maybe_gap();
      send_tick(4'hF, 4'hF, '0, '0);
    end

    // lowered debounce caps running counts; no idling from here on
    program_cfg(16'd16384, 8'd2, 15'd200);
    calm = 1'b1;
    run_random(220, 15);

    settle();
    if ((fail_count == 0) && (pending == 0)) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lcst_pkg.sv
hdl/lcst_lane.sv
hdl/lcst_merge.sv
hdl/leg_contact_state_tracker.sv
bench/lcst_checker.sv
bench/leg_contact_state_tracker_tb.sv
